>>> src/modexp_pkg.sv
// Package for the modular exponentiation block: word width, sequencer state
// and operation codes. No dependencies.
`default_nettype none

package modexp_pkg;

    localparam int WORD_BITS = 32;
    localparam int FIELD_W   = 32;
    localparam int CNT_W     = $clog2(WORD_BITS);

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [CNT_W-1:0]     t_cnt;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MUL  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    // Operation the shared modular multiplier is running
    typedef enum logic [1:0] {
        OP_REDUCE,
        OP_MULRES,
        OP_SQUARE
    } t_op;

endpackage

`default_nettype wire

>>> src/modular_exponentiation.sv
// Modular exponentiation, right-to-left square-and-multiply, on one shared
// bit-serial modular multiplier. Depends on modexp_pkg.
//
// Special cases (zero modulus, base or exponent) go straight to the done
// state. Otherwise the work is one reduction of the base, one multiply for
// each set exponent bit and one squaring for each bit below the highest set
// bit; each multiply takes a doubling step per multiplier bit and an add
// step per set multiplier bit.
// Throughput: one item at a time; the input side is ready only when the
// sequencer is idle, and a finished result waits in the output register.
// Reset (synchronous, active low) clears the sequencer and the output valid.
`default_nettype none

module modular_exponentiation (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [modexp_pkg::FIELD_W-1:0] i_base_value,
    input  wire logic [modexp_pkg::FIELD_W-1:0] i_exponent_value,
    input  wire logic [modexp_pkg::FIELD_W-1:0] i_modulus_value,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [modexp_pkg::FIELD_W-1:0]    o_residue_out,
    output logic                              o_zero_modulus_error
);
    import modexp_pkg::*;

    // Sequencer
    t_state r_state;
    t_op    r_op;

    // Item operands and running values
    t_word  r_mod;      // modulus
    t_word  r_exp;      // exponent, shifted right one bit per squaring
    t_word  r_res;      // running residue
    t_word  r_base;     // current base power
    logic   r_err;

    // Shared multiplier: acc = a * b mod m, scanning b from its top bit.
    // Each bit takes a doubling step and, when the bit is set, an add step.
    t_word  r_acc;
    t_word  r_mula;
    t_word  r_mulb;
    t_cnt   r_cnt;
    logic   r_phase;    // 0: double, 1: add multiplicand

    // Output register
    logic          r_out_valid;
    logic [FIELD_W-1:0] r_out_residue;
    logic          r_out_err;

    // Input views at the word width
    t_word  in_base;
    t_word  in_exp;
    t_word  in_mod;
    t_word  in_one_mod;

    // Shared add-mod unit
    t_word  add_y;
    t_word  add_gap;
    t_word  n_acc;
    logic   step_done;
    logic   op_done;

    assign in_base    = WORD_BITS'(i_base_value);
    assign in_exp     = WORD_BITS'(i_exponent_value);
    assign in_mod     = WORD_BITS'(i_modulus_value);
    // 1 mod m: zero only for a modulus of one
    assign in_one_mod = (in_mod == t_word'(1)) ? '0 : t_word'(1);

    // (acc + y) mod m for acc, y < m, without a wider sum
    always_comb begin
        add_y   = r_phase ? r_mula : r_acc;
        add_gap = r_mod - add_y;
        n_acc   = (r_acc >= add_gap) ? (r_acc - add_gap) : (r_acc + add_y);
    end

    // Finish the current multiplier bit after the double when it is clear
    assign step_done = r_phase || !r_mulb[WORD_BITS-1];
    assign op_done   = step_done && (r_cnt == '0);

    assign o_in_ready           = (r_state == S_IDLE);
    assign o_out_valid          = r_out_valid;
    assign o_residue_out        = r_out_residue;
    assign o_zero_modulus_error = r_out_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // Drop the result once taken; the done state reloads it itself
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_mod  <= in_mod;
                        r_exp  <= in_exp;
                        r_err  <= (in_mod == '0);
                        // Zero modulus and zero base give 0, zero exponent gives 1
                        if (in_mod == '0 || in_base == '0) begin
                            r_res   <= '0;
                            r_state <= S_DONE;
                        end else if (in_exp == '0) begin
                            r_res   <= t_word'(1);
                            r_state <= S_DONE;
                        end else begin
                            // Reduce the base as (1 mod m) * base mod m
                            r_res   <= in_one_mod;
                            r_op    <= OP_REDUCE;
                            r_mula  <= in_one_mod;
                            r_mulb  <= in_base;
                            r_acc   <= '0;
                            r_cnt   <= t_cnt'(WORD_BITS - 1);
                            r_phase <= 1'b0;
                            r_state <= S_MUL;
                        end
                    end
                end

                S_MUL: begin
                    if (op_done) begin
                        // Start the next multiply from a cleared accumulator
                        r_acc   <= '0;
                        r_cnt   <= t_cnt'(WORD_BITS - 1);
                        r_phase <= 1'b0;
                        case (r_op)
                            OP_REDUCE: begin
                                r_base <= n_acc;
                                if (r_exp[0]) begin
                                    r_op   <= OP_MULRES;
                                    r_mula <= r_res;
                                    r_mulb <= n_acc;
                                end else begin
                                    r_op   <= OP_SQUARE;
                                    r_mula <= n_acc;
                                    r_mulb <= n_acc;
                                end
                            end
                            OP_MULRES: begin
                                r_res <= n_acc;
                                // Skip the squaring when no higher bit is set
                                if ((r_exp >> 1) == '0) begin
                                    r_state <= S_DONE;
                                end else begin
                                    r_op   <= OP_SQUARE;
                                    r_mula <= r_base;
                                    r_mulb <= r_base;
                                end
                            end
                            OP_SQUARE: begin
                                r_base <= n_acc;
                                r_exp  <= r_exp >> 1;
                                if ((r_exp >> 1) == '0) begin
                                    r_state <= S_DONE;
                                end else if (r_exp[1]) begin
                                    r_op   <= OP_MULRES;
                                    r_mula <= r_res;
                                    r_mulb <= n_acc;
                                end else begin
                                    r_op   <= OP_SQUARE;
                                    r_mula <= n_acc;
                                    r_mulb <= n_acc;
                                end
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end else begin
                        r_acc <= n_acc;
                        if (step_done) begin
                            r_phase <= 1'b0;
                            r_mulb  <= r_mulb << 1;
                            r_cnt   <= r_cnt - t_cnt'(1);
                        end else begin
                            r_phase <= 1'b1;
                        end
                    end
                end

                S_DONE: begin
                    // Hold the result until the output register is free
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid   <= 1'b1;
                        r_out_residue <= FIELD_W'(r_res);
                        r_out_err     <= r_err;
                        r_state       <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // The multiplier operands stay reduced below the modulus
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_acc < r_mod && r_mula < r_mod))
        else $error("multiplier operand not reduced below modulus");

    // An error result always carries a zero residue
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_err) |-> (r_out_residue == '0))
        else $error("error result with nonzero residue");

    // One item at a time: no second accept right after an accept
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready right after an accepted item");

    // A result is loaded only from the done state
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result loaded outside the done state");

endmodule

`default_nettype wire

>>> tb/sv/modular_exponentiation_tb.sv
// Testbench for modular_exponentiation: directed corner items and random items through
// the valid/ready ports, each result checked against an in-bench square-and-multiply model.
// Depends on modexp_pkg and the modular_exponentiation RTL.
`default_nettype none

module modular_exponentiation_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import modexp_pkg::*;

    // One expected result: residue and zero-modulus flag
    typedef struct {
        t_word residue;
        logic  zero_mod;
    } t_residue_exp;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [FIELD_W-1:0]   i_base_value;
    logic [FIELD_W-1:0]   i_exponent_value;
    logic [FIELD_W-1:0]   i_modulus_value;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [FIELD_W-1:0]   o_residue_out;
    logic                 o_zero_modulus_error;

    // Results still owed by the block, oldest first
    t_residue_exp pending_residues[$];
    int           n_errors = 0;
    // While set, neither side idles: gives back-to-back stretches
    bit           calm = 1'b0;

    modular_exponentiation uut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_base_value         (i_base_value),
        .i_exponent_value     (i_exponent_value),
        .i_modulus_value      (i_modulus_value),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_residue_out        (o_residue_out),
        .o_zero_modulus_error (o_zero_modulus_error)
    );

    always #5 i_clk = ~i_clk;

    // Hard stop: ~140 items at worst-case latency plus longest gaps and stalls
    // take under 10 ms; allow several times that.
    initial begin
        #(40_000_000);
        $display("FAIL modular_exponentiation");
        $finish;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 20);
        else
            return $urandom_range(50, 300);
    endfunction

    // Square-and-multiply at double width; the zero-modulus check comes first,
    // then zero base (even with zero exponent), then zero exponent.
    function automatic t_residue_exp modpow_expected(t_word base, t_word expo, t_word modulus);
        t_residue_exp res;
        logic [63:0]  acc;
        logic [63:0]  power;
        logic [63:0]  m64;
        m64 = {32'd0, modulus};
        res.zero_mod = 1'b0;
        if (modulus == '0) begin
            res.residue  = '0;
            res.zero_mod = 1'b1;
        end else if (base == '0) begin
            res.residue = '0;
        end else if (expo == '0) begin
            // One even when the modulus is one
            res.residue = t_word'(1);
        end else begin
            power = {32'd0, base} % m64;
            acc   = 64'd1 % m64;
            for (int i = 0; i < WORD_BITS; i++) begin
                if (expo[i])
                    acc = (acc * power) % m64;
                power = (power * power) % m64;
            end
            res.residue = acc[31:0];
        end
        return res;
    endfunction

    // Drive one item, hold it until accepted, then record what it must return.
    // Valid is only lowered when a gap follows, so it never drops and rises
    // within one time step.
    task automatic send_item(input t_word base, input t_word expo, input t_word modulus);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_base_value     <= base;
        i_exponent_value <= expo;
        i_modulus_value  <= modulus;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_residues.push_back(modpow_expected(base, expo, modulus));
    endtask

    // Drop valid and hold off until every owed result has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_residues.size() != 0) @(posedge i_clk);
    endtask

    // Receiver side: runs of ready, broken by random stalls unless calm
    initial begin
        int run;
        int stall;
        i_out_ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            run = calm ? 64 : $urandom_range(1, 24);
            i_out_ready <= 1'b1;
            repeat (run) @(posedge i_clk);
            stall = calm ? 0 : pick_gap();
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    // Compare every accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_residue_exp want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_residues.size() == 0) begin
                $error("unexpected result: residue_out %h, zero_modulus_error %b",
                       o_residue_out, o_zero_modulus_error);
                n_errors++;
            end else begin
                want = pending_residues.pop_front();
                if (o_residue_out !== want.residue) begin
                    $error("residue_out: expected %h, actual %h", want.residue, o_residue_out);
                    n_errors++;
                end
                if (o_zero_modulus_error !== want.zero_mod) begin
                    $error("zero_modulus_error: expected %b, actual %b",
                           want.zero_mod, o_zero_modulus_error);
                    n_errors++;
                end
            end
        end
    end

    // Zero modulus wins over everything, zero base over zero exponent,
    // and modulus one still gives one for a zero exponent.
    task automatic test_special_cases();
        send_item(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_item(32'hffff_ffff, 32'hffff_ffff, 32'h0000_0000);
        send_item(32'h0000_0005, 32'h0000_0000, 32'h0000_0000);
        send_item(32'h0000_0000, 32'h0000_0000, 32'h0000_0007);
        send_item(32'h0000_0000, 32'h0000_0005, 32'h0000_000d);
        send_item(32'h0000_0005, 32'h0000_0000, 32'h0000_000d);
        send_item(32'h0000_0005, 32'h0000_0000, 32'h0000_0001);
        send_item(32'h0000_3039, 32'h0000_0007, 32'h0000_0001);
    endtask

    // Field extremes, base at or above the modulus, single-bit exponents
    task automatic test_extremes();
        send_item(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_item(32'hffff_ffff, 32'hffff_ffff, 32'hffff_fffb);
        send_item(32'h0000_0002, 32'hffff_ffff, 32'hffff_ffff);
        send_item(32'hffff_fffe, 32'h0000_0002, 32'hffff_ffff);
        send_item(32'h0000_0003, 32'h0000_0001, 32'h0000_0007);
        send_item(32'h0000_000a, 32'h0000_0001, 32'h0000_0007);
        send_item(32'h0000_0007, 32'h0000_0003, 32'h0000_0007);
        send_item(32'h0000_0002, 32'h8000_0000, 32'hffff_fff1);
        send_item(32'h0000_0001, 32'hffff_ffff, 32'h0000_0002);
        send_item(32'hffff_ffff, 32'h0000_0001, 32'h8000_0000);
        send_item(32'h0000_0003, 32'h0000_0010, 32'h8000_0001);
        send_item(32'h8000_0000, 32'h5555_5555, 32'haaaa_aaab);
    endtask

    // Sender waits for the block to empty completely, then resumes
    task automatic test_drain_pause();
        for (int i = 0; i < 4; i++)
            send_item($urandom, $urandom, $urandom | 32'h1);
        wait_drained();
        for (int i = 0; i < 4; i++)
            send_item($urandom, $urandom_range(0, 255), $urandom_range(1, 1000));
    endtask

    // Random operands, weighted toward full-width values with a share of
    // small moduli, short exponents and the zero cases; alternate blocks of
    // idling and back-to-back traffic.
    task automatic test_random(input int n_items);
        t_word base;
        t_word expo;
        t_word modulus;
        int    kind;
        for (int i = 0; i < n_items; i++) begin
            if (i % 20 == 0)
                calm = ($urandom_range(0, 3) == 0);
            base    = $urandom;
            expo    = $urandom;
            modulus = $urandom;
            kind    = $urandom_range(0, 99);
            if (kind < 12)
                modulus = $urandom_range(1, 255);
            else if (kind < 20)
                modulus = '0;
            else if (kind < 25)
                base = '0;
            else if (kind < 30)
                expo = '0;
            else if (kind < 42)
                expo = $urandom_range(1, 64);
            else if (kind < 47)
                base = modulus + $urandom_range(0, 3);
            send_item(base, expo, modulus);
        end
        calm = 1'b0;
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        i_in_valid       <= 1'b0;
        i_base_value     <= '0;
        i_exponent_value <= '0;
        i_modulus_value  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_special_cases();
        test_extremes();
        test_drain_pause();
        test_random(112);

        // Drop valid, let every result come home, then idle before the verdict
        i_in_valid <= 1'b0;
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (n_errors == 0)
            $display("PASS modular_exponentiation");
        else
            $display("FAIL modular_exponentiation");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
src/modexp_pkg.sv
src/modular_exponentiation.sv
tb/sv/modular_exponentiation_tb.sv
